### hdl/abpe_pkg.sv
// Shared types, register indexes, constants and tables of the ADPCM-B playback engine.
// No dependencies.
package abpe_pkg;

    localparam int STORE_BYTES_DEF = 65536;
    localparam int PHASE_BITS_DEF  = 16;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CTRL  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_END    = 3'd1;
    localparam logic [2:0] REG_LIMIT  = 3'd2;
    localparam logic [2:0] REG_RATE   = 3'd3;
    localparam logic [2:0] REG_VOLUME = 3'd4;
    localparam logic [2:0] REG_PAN    = 3'd5;

    localparam logic [7:0] MODE_MASK   = 8'hF1;
    localparam logic [7:0] MODE_SEL    = 8'hE0;
    localparam logic [7:0] MODE_PLAY_M = 8'hA0;
    localparam logic [7:0] MODE_PLAY_C = 8'h80;
    localparam logic [7:0] MODE_WR_M   = 8'h60;
    localparam logic [7:0] MODE_RD_M   = 8'h20;

    localparam logic [23:0] LIMIT_OFF = 24'hFFFFFF;
    localparam logic [14:0] STEP_MAX  = 15'd24576;
    localparam logic [14:0] STEP_MIN  = 15'd127;
    localparam logic [14:0] STEP_INIT = 15'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_in;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               sample_valid;
        logic [1:0]         mix_select;
        logic [7:0]         read_byte;
        logic               end_event;
        logic               buffer_ready;
        logic               playing;
    } t_out;

    typedef struct packed {
        logic       is_tick;
        logic       is_ctrl;
        logic       is_write;
        logic       is_read;
        logic [7:0] value;
    } t_cmd;

    function automatic logic [7:0] grow_factor(input logic [3:0] code);
        logic [7:0] g;
        case (code[2:0])
            3'd4:    g = 8'd77;
            3'd5:    g = 8'd102;
            3'd6:    g = 8'd128;
            3'd7:    g = 8'd153;
            default: g = 8'd57;
        endcase
        return g;
    endfunction

endpackage

### hdl/abpe_front.sv
// Front end: accepts input items, classifies them by kind and queues them.
// Depends on abpe_pkg.
module abpe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abpe_pkg::t_in   i_in,
    output logic            o_full,
    output logic            o_cmd_valid,
    output abpe_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);

    abpe_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    abpe_pkg::t_cmd w_cls;
    logic           w_push, w_take;

    always_comb begin
        w_cls.is_tick  = (i_in.kind == abpe_pkg::KIND_TICK);
        w_cls.is_ctrl  = (i_in.kind == abpe_pkg::KIND_CTRL);
        w_cls.is_write = (i_in.kind == abpe_pkg::KIND_WRITE);
        w_cls.is_read  = (i_in.kind == abpe_pkg::KIND_READ);
        w_cls.value    = i_in.value;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_take      = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_take);
        end
    end

endmodule

### hdl/abpe_engine.sv
// Back end: sequencer that executes queued items, holds the byte store and the result register.
// Depends on abpe_pkg.
module abpe_engine #(
    parameter int STORE_BYTES = abpe_pkg::STORE_BYTES_DEF,
    parameter int PHASE_BITS  = abpe_pkg::PHASE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [23:0]     i_cfg_data,
    input  logic            i_cmd_valid,
    input  abpe_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    output logic            o_empty,
    output abpe_pkg::t_out  o_out,
    input  logic            i_pop
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int SUM_W = ((PHASE_BITS > 20) ? PHASE_BITS : 20) + 1;
    localparam int CNT_W = SUM_W - PHASE_BITS;
    localparam int MW    = 16 + PHASE_BITS + 2;
    localparam logic [24:0] STORE_LIM = 25'(STORE_BYTES);
    localparam logic [23:0] STORE_TOP = 24'(STORE_BYTES - 1);
    localparam logic [PHASE_BITS:0] W_ONE = {1'b1, {PHASE_BITS{1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NIB   = 4'd1;
    localparam logic [3:0] S_CNIB  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_DEC1  = 4'd5;
    localparam logic [3:0] S_DEC2  = 4'd6;
    localparam logic [3:0] S_INT1  = 4'd7;
    localparam logic [3:0] S_INT2  = 4'd8;
    localparam logic [3:0] S_INT3  = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_RDL   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [7:0] r_store [STORE_BYTES];
    logic [7:0] r_rdata;

    logic [3:0]  r_state, n_state;
    logic [23:0] r_start, r_end, n_end, r_limit;
    logic [19:0] r_rate;
    logic [7:0]  r_vol;
    logic [1:0]  r_pan;
    logic [24:0] r_addr, n_addr;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic signed [15:0] r_pred, n_pred, r_prev, n_prev;
    logic [14:0] r_step, n_step;
    logic [7:0]  r_held, n_held, r_cpu, n_cpu, r_mode, n_mode;
    logic        r_busy, n_busy, r_ready, n_ready, r_endev, n_endev;
    logic [1:0]  r_dummy, n_dummy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]  r_code, n_code;
    logic [18:0] r_pa, n_pa;
    logic [22:0] r_ps, n_ps;
    logic signed [MW-1:0] r_m1, n_m1, r_m2, n_m2;
    logic signed [16:0] r_q, n_q;
    logic [23:0] r_smp, n_smp;
    logic        r_vs, n_vs;
    logic [7:0]  r_rd, n_rd;
    abpe_pkg::t_out r_out;
    logic        r_out_v, n_out_v;

    logic        w_we;
    logic [24:0] w_a;
    logic [SUM_W-1:0] w_sum;
    logic        w_stop;
    logic [7:0]  w_mb;
    logic signed [17:0] w_acc;
    logic [16:0] w_sg;
    logic signed [MW:0] w_x;
    logic signed [25:0] w_prod;

    function automatic logic [AW-1:0] r_addr_w_idx(input logic [24:0] a);
        logic [24:0] b;
        b = a - 25'd2;
        return b[AW:1];
    endfunction

    assign o_empty    = !r_out_v;
    assign o_out      = r_out;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        n_addr  = r_addr;
        n_phase = r_phase;
        n_pred  = r_pred;
        n_prev  = r_prev;
        n_step  = r_step;
        n_held  = r_held;
        n_cpu   = r_cpu;
        n_mode  = r_mode;
        n_busy  = r_busy;
        n_ready = r_ready;
        n_endev = r_endev;
        n_dummy = r_dummy;
        n_cnt   = r_cnt;
        n_code  = r_code;
        n_pa    = r_pa;
        n_ps    = r_ps;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_q     = r_q;
        n_smp   = r_smp;
        n_vs    = r_vs;
        n_rd    = r_rd;
        n_out_v = r_out_v && !i_pop;
        w_we    = 1'b0;
        w_a     = r_addr;
        w_sum   = SUM_W'(r_phase) + SUM_W'(r_rate);
        w_stop  = 1'b0;
        w_mb    = i_cmd.value & abpe_pkg::MODE_MASK;
        w_acc   = '0;
        w_sg    = '0;
        w_x     = '0;
        w_prod  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_endev = 1'b0;
                    n_rd    = 8'd0;
                    n_vs    = 1'b0;
                    n_smp   = 24'd0;
                    n_state = S_DONE;
                    if (i_cmd.is_tick) begin
                        if ((r_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_PLAY_M) begin
                            n_phase = w_sum[PHASE_BITS-1:0];
                            n_cnt   = w_sum[SUM_W-1:PHASE_BITS];
                            n_state = S_NIB;
                        end else if ((r_mode & abpe_pkg::MODE_SEL) ==
                                     abpe_pkg::MODE_PLAY_C) begin
                            n_phase = w_sum[PHASE_BITS-1:0];
                            n_cnt   = w_sum[SUM_W-1:PHASE_BITS];
                            n_state = S_CNIB;
                        end
                    end else if (i_cmd.is_ctrl) begin
                        if (w_mb[7]) begin
                            n_busy  = 1'b1;
                            n_phase = '0;
                            n_pred  = '0;
                            n_prev  = '0;
                            n_step  = abpe_pkg::STEP_INIT;
                            n_held  = 8'd0;
                        end
                        if (w_mb[5]) begin
                            n_addr  = {r_start, 1'b0};
                            n_dummy = 2'd2;
                            if ({1'b0, r_end} >= STORE_LIM) begin
                                n_end = STORE_TOP;
                            end
                            if ({1'b0, r_start} >= STORE_LIM) begin
                                w_mb   = 8'd0;
                                n_busy = 1'b0;
                            end
                        end else begin
                            n_addr = '0;
                        end
                        if (w_mb[0]) begin
                            w_mb    = 8'd0;
                            n_busy  = 1'b0;
                            n_ready = 1'b1;
                        end
                        n_mode = w_mb;
                    end else if (i_cmd.is_write) begin
                        if ((r_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_WR_M) begin
                            if (r_dummy != 2'd0) begin
                                w_a     = {r_start, 1'b0};
                                n_dummy = 2'd0;
                            end
                            if (w_a != {r_end, 1'b0}) begin
                                if ({1'b0, w_a[24:1]} < STORE_LIM) begin
                                    w_we    = 1'b1;
                                    w_a     = w_a + 25'd2;
                                    n_ready = 1'b1;
                                end
                            end else begin
                                n_endev = 1'b1;
                            end
                            n_addr = w_a;
                        end else if ((r_mode & abpe_pkg::MODE_SEL) ==
                                     abpe_pkg::MODE_PLAY_C) begin
                            n_cpu   = i_cmd.value;
                            n_ready = 1'b0;
                        end
                    end else if (i_cmd.is_read) begin
                        if ((r_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_RD_M) begin
                            if (r_dummy != 2'd0) begin
                                n_addr  = {r_start, 1'b0};
                                n_dummy = r_dummy - 2'd1;
                            end else if (r_addr != {r_end, 1'b0}) begin
                                if ({1'b0, r_addr[24:1]} < STORE_LIM) begin
                                    n_state = S_RDW;
                                end
                            end else begin
                                n_endev = 1'b1;
                            end
                        end
                    end
                end
            end
            S_RDW: n_state = S_RDL;
            S_RDL: begin
                n_rd    = r_rdata;
                n_addr  = r_addr + 25'd2;
                n_ready = 1'b1;
                n_state = S_DONE;
            end
            S_NIB: begin
                if (r_cnt == '0) begin
                    n_vs    = 1'b1;
                    n_state = S_INT1;
                end else begin
                    if (r_limit != abpe_pkg::LIMIT_OFF && w_a == {r_limit, 1'b0}) begin
                        w_a = '0;
                    end
                    if ({1'b0, w_a[24:1]} >= STORE_LIM) begin
                        w_stop = 1'b1;
                    end else if (w_a == {r_end, 1'b0}) begin
                        if (r_mode[4]) begin
                            w_a    = {r_start, 1'b0};
                            n_pred = '0;
                            n_step = abpe_pkg::STEP_INIT;
                            n_prev = '0;
                            if ({1'b0, w_a[24:1]} >= STORE_LIM) begin
                                w_stop = 1'b1;
                            end
                        end else begin
                            w_stop = 1'b1;
                        end
                    end
                    n_addr = w_a;
                    if (w_stop) begin
                        n_endev = 1'b1;
                        n_busy  = 1'b0;
                        n_mode  = 8'd0;
                        n_prev  = '0;
                        n_vs    = 1'b0;
                        n_state = S_DONE;
                    end else if (w_a[0]) begin
                        n_code  = r_held[3:0];
                        n_state = S_DEC1;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD: begin
                n_held  = r_rdata;
                n_code  = r_rdata[7:4];
                n_state = S_DEC1;
            end
            S_CNIB: begin
                if (r_cnt == '0) begin
                    n_vs    = 1'b1;
                    n_state = S_INT1;
                end else begin
                    if (r_addr[0]) begin
                        n_code  = r_held[3:0];
                        n_held  = r_cpu;
                        n_ready = 1'b1;
                    end else begin
                        n_code = r_held[7:4];
                    end
                    n_state = S_DEC1;
                end
            end
            S_DEC1: begin
                n_addr  = r_addr + 25'd1;
                n_pa    = 19'({r_code[2:0], 1'b1}) * 19'(r_step);
                n_ps    = 23'(r_step) * 23'(abpe_pkg::grow_factor(r_code));
                n_state = S_DEC2;
            end
            S_DEC2: begin
                if (r_code[3]) begin
                    w_acc = 18'(r_pred) - $signed({2'b00, r_pa[18:3]});
                end else begin
                    w_acc = 18'(r_pred) + $signed({2'b00, r_pa[18:3]});
                end
                n_prev = r_pred;
                if (w_acc > 18'sd32767) begin
                    n_pred = 16'sh7FFF;
                end else if (w_acc < -18'sd32768) begin
                    n_pred = -16'sh8000;
                end else begin
                    n_pred = w_acc[15:0];
                end
                w_sg = r_ps[22:6];
                if (w_sg > 17'(abpe_pkg::STEP_MAX)) begin
                    n_step = abpe_pkg::STEP_MAX;
                end else if (w_sg < 17'(abpe_pkg::STEP_MIN)) begin
                    n_step = abpe_pkg::STEP_MIN;
                end else begin
                    n_step = w_sg[14:0];
                end
                n_cnt   = r_cnt - CNT_W'(1);
                n_state = r_mode[5] ? S_NIB : S_CNIB;
            end
            S_INT1: begin
                n_m1    = MW'(r_prev) * $signed(MW'(W_ONE - (PHASE_BITS + 1)'(r_phase)));
                n_m2    = MW'(r_pred) * $signed(MW'(r_phase));
                n_state = S_INT2;
            end
            S_INT2: begin
                w_x     = (MW + 1)'(r_m1) + (MW + 1)'(r_m2);
                n_q     = w_x[PHASE_BITS+16:PHASE_BITS];
                n_state = S_INT3;
            end
            S_INT3: begin
                w_prod  = 26'(r_q) * $signed({18'd0, r_vol});
                n_smp   = w_prod[23:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || i_pop) begin
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_addr_w_idx(w_a)] <= i_cmd.value;
        end
        if (r_state == S_FETCH || r_state == S_RDW) begin
            r_rdata <= r_store[r_addr[AW:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= n_pa;
        r_ps   <= n_ps;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_q    <= n_q;
        r_code <= n_code;
        r_cnt  <= n_cnt;
        r_smp  <= n_smp;
        r_rd   <= n_rd;
        if (r_state == S_DONE && (!r_out_v || i_pop)) begin
            r_out.sample       <= r_vs ? r_smp : 24'd0;
            r_out.sample_valid <= r_vs;
            r_out.mix_select   <= r_vs ? r_pan : 2'd0;
            r_out.read_byte    <= r_rd;
            r_out.end_event    <= r_endev;
            r_out.buffer_ready <= r_ready;
            r_out.playing      <= r_busy;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_end   <= '0;
            r_limit <= abpe_pkg::LIMIT_OFF;
            r_rate  <= '0;
            r_vol   <= '0;
            r_pan   <= '0;
            r_addr  <= '0;
            r_phase <= '0;
            r_pred  <= '0;
            r_prev  <= '0;
            r_step  <= abpe_pkg::STEP_INIT;
            r_held  <= '0;
            r_cpu   <= '0;
            r_mode  <= '0;
            r_busy  <= 1'b0;
            r_ready <= 1'b1;
            r_endev <= 1'b0;
            r_dummy <= '0;
            r_vs    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_phase <= n_phase;
            r_pred  <= n_pred;
            r_prev  <= n_prev;
            r_step  <= n_step;
            r_held  <= n_held;
            r_cpu   <= n_cpu;
            r_mode  <= n_mode;
            r_busy  <= n_busy;
            r_ready <= n_ready;
            r_endev <= n_endev;
            r_dummy <= n_dummy;
            r_vs    <= n_vs;
            r_out_v <= n_out_v;
            r_end   <= n_end;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    abpe_pkg::REG_START:  r_start <= i_cfg_data;
                    abpe_pkg::REG_END:    r_end   <= i_cfg_data;
                    abpe_pkg::REG_LIMIT:  r_limit <= i_cfg_data;
                    abpe_pkg::REG_RATE:   r_rate  <= i_cfg_data[19:0];
                    abpe_pkg::REG_VOLUME: r_vol   <= i_cfg_data[7:0];
                    abpe_pkg::REG_PAN:    r_pan   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### hdl/adpcm_b_playback_engine_unit.sv
// Top level of the ADPCM-B playback engine: input queue, execution engine, result register.
// Depends on abpe_pkg, abpe_front and abpe_engine.
// The engine handles one item at a time and takes the next queued item only from its idle state.
// Reset (synchronous, active low) clears queue, flags and decoder; the byte store is not cleared.
module adpcm_b_playback_engine_unit #(
    parameter int STORE_BYTES = abpe_pkg::STORE_BYTES_DEF,
    parameter int PHASE_BITS  = abpe_pkg::PHASE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  abpe_pkg::t_in   i_in,
    output logic            empty,
    input  logic            pop,
    output abpe_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [23:0]     i_cfg_data
);

    logic           w_cmd_valid, w_cmd_take;
    abpe_pkg::t_cmd w_cmd;

    abpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    abpe_engine #(
        .STORE_BYTES (STORE_BYTES),
        .PHASE_BITS  (PHASE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .o_out       (o_out),
        .i_pop       (pop)
    );

    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.sample_valid) |-> (o_out.sample == 24'sd0 && o_out.mix_select == 2'd0))
        else $error("sample or mix set without valid sample");

    a_valid_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.sample_valid) |-> (o_out.read_byte == 8'd0 && !o_out.end_event))
        else $error("sample result carries read data or end status");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

### bench/tb_adpcm_b_playback_engine_unit.sv
// Self-checking bench for the ADPCM-B playback engine: a behavioral decoder
// predicts every result of every request and a checker process compares them.
// Depends on abpe_pkg and the adpcm_b_playback_engine_unit RTL.
module tb_adpcm_b_playback_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 65536;
    localparam int PB = 16;

    logic i_clk, i_rst_n, push, full, empty, pop;
    abpe_pkg::t_in i_in;
    abpe_pkg::t_out o_out;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [23:0] i_cfg_data;

    adpcm_b_playback_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // model state
    logic [23:0] m_start, m_end, m_limit;
    logic [19:0] m_rate;
    logic [7:0] m_vol;
    logic [1:0] m_pan;
    logic [7:0] m_store [SB];
    bit m_written [SB];
    bit m_bad_read;
    logic [24:0] m_addr;
    logic [PB-1:0] m_phase;
    int m_acc, m_prev, m_step;
    logic [7:0] m_held, m_cpu, m_mode;
    logic m_busy, m_ready, m_end_ev;
    int m_dummy;

    abpe_pkg::t_out expected_q[$];
    int errors = 0;
    int send_idle = 17, recv_idle = 48;
    bit hold_recv = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    function automatic void decode_nibble(input logic [3:0] code);
        int a, s, d, g;
        d = (code[2:0] * 2 + 1) * (code[3] ? -1 : 1);
        case (code[2:0])
            3'd4: g = 77;
            3'd5: g = 102;
            3'd6: g = 128;
            3'd7: g = 153;
            default: g = 57;
        endcase
        m_prev = m_acc;
        a = m_acc + (d * m_step) / 8;
        if (a > 32767) a = 32767;
        else if (a < -32768) a = -32768;
        m_acc = a;
        s = (m_step * g) / 64;
        if (s > 24576) s = 24576;
        else if (s < 127) s = 127;
        m_step = s;
    endfunction

    function automatic int advance_phase();
        longint t;
        t = longint'(m_phase) + longint'(m_rate);
        m_phase = t[PB-1:0];
        return int'(t >> PB);
    endfunction

    function automatic logic [23:0] interp();
        longint w, x, q;
        w = longint'(1) << PB;
        x = longint'(m_prev) * (w - longint'(m_phase)) + longint'(m_acc) * longint'(m_phase);
        if (x >= 0) q = x >>> PB;
        else q = -((-x + w - 1) >>> PB);
        q = q * longint'(m_vol);
        return q[23:0];
    endfunction

    function automatic bit stop_play();
        m_end_ev = 1;
        m_busy = 0;
        m_mode = 0;
        m_prev = 0;
        return 0;
    endfunction

    function automatic bit play_store();
        int n;
        logic [3:0] code;
        n = advance_phase();
        while (n > 0) begin
            if (m_limit != abpe_pkg::LIMIT_OFF && m_addr == {m_limit, 1'b0}) m_addr = 0;
            if ((m_addr >> 1) >= SB) return stop_play();
            if (m_addr == {m_end, 1'b0}) begin
                if (m_mode[4]) begin
                    m_addr = {m_start, 1'b0};
                    m_acc = 0;
                    m_step = 127;
                    m_prev = 0;
                    if ((m_addr >> 1) >= SB) return stop_play();
                end else return stop_play();
            end
            if (m_addr[0]) code = m_held[3:0];
            else begin
                if (!m_written[m_addr >> 1]) m_bad_read = 1;
                m_held = m_store[m_addr >> 1];
                code = m_held[7:4];
            end
            m_addr = m_addr + 1;
            decode_nibble(code);
            n--;
        end
        return 1;
    endfunction

    // dry run of a store playback tick: does it fetch an entry never written
    function automatic bit tick_reads_unwritten();
        logic [24:0] s_addr;
        logic [PB-1:0] s_phase;
        int s_acc, s_prev, s_step;
        logic [7:0] s_held, s_mode;
        logic s_busy, s_end_ev;
        bit bad;
        s_addr = m_addr;
        s_phase = m_phase;
        s_acc = m_acc;
        s_prev = m_prev;
        s_step = m_step;
        s_held = m_held;
        s_mode = m_mode;
        s_busy = m_busy;
        s_end_ev = m_end_ev;
        m_bad_read = 0;
        void'(play_store());
        bad = m_bad_read;
        m_addr = s_addr;
        m_phase = s_phase;
        m_acc = s_acc;
        m_prev = s_prev;
        m_step = s_step;
        m_held = s_held;
        m_mode = s_mode;
        m_busy = s_busy;
        m_end_ev = s_end_ev;
        return bad;
    endfunction

    function automatic abpe_pkg::t_out predict_result(input abpe_pkg::t_in req);
        abpe_pkg::t_out r;
        int n;
        logic [3:0] code;
        r = '0;
        m_end_ev = 0;
        case (req.kind)
            abpe_pkg::KIND_TICK: begin
                if ((m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_PLAY_M)
                    r.sample_valid = play_store();
                else if ((m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_PLAY_C) begin
                    n = advance_phase();
                    while (n > 0) begin
                        if (m_addr[0]) begin
                            code = m_held[3:0];
                            m_held = m_cpu;
                            m_ready = 1;
                        end else code = m_held[7:4];
                        m_addr = m_addr + 1;
                        decode_nibble(code);
                        n--;
                    end
                    r.sample_valid = 1;
                end
                if (r.sample_valid) begin
                    r.sample = interp();
                    r.mix_select = m_pan;
                end
            end
            abpe_pkg::KIND_CTRL: begin
                m_mode = req.value & abpe_pkg::MODE_MASK;
                if (m_mode[7]) begin
                    m_busy = 1;
                    m_phase = 0;
                    m_acc = 0;
                    m_prev = 0;
                    m_step = 127;
                    m_held = 0;
                end
                if (m_mode[5]) begin
                    m_addr = {m_start, 1'b0};
                    m_dummy = 2;
                    if (m_end >= SB) m_end = SB - 1;
                    if (m_start >= SB) begin
                        m_mode = 0;
                        m_busy = 0;
                    end
                end else m_addr = 0;
                if (m_mode[0]) begin
                    m_mode = 0;
                    m_busy = 0;
                    m_ready = 1;
                end
            end
            abpe_pkg::KIND_WRITE: begin
                if ((m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_WR_M) begin
                    if (m_dummy != 0) begin
                        m_addr = {m_start, 1'b0};
                        m_dummy = 0;
                    end
                    if (m_addr != {m_end, 1'b0}) begin
                        if ((m_addr >> 1) < SB) begin
                            m_store[m_addr >> 1] = req.value;
                            m_written[m_addr >> 1] = 1;
                            m_addr = m_addr + 2;
                            m_ready = 1;
                        end
                    end else m_end_ev = 1;
                end else if ((m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_PLAY_C) begin
                    m_cpu = req.value;
                    m_ready = 0;
                end
            end
            default: begin
                if ((m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_RD_M) begin
                    if (m_dummy != 0) begin
                        m_addr = {m_start, 1'b0};
                        m_dummy--;
                    end else if (m_addr != {m_end, 1'b0}) begin
                        if ((m_addr >> 1) < SB) begin
                            r.read_byte = m_store[m_addr >> 1];
                            m_addr = m_addr + 2;
                            m_ready = 1;
                        end
                    end else m_end_ev = 1;
                end
            end
        endcase
        r.end_event = m_end_ev;
        r.buffer_ready = m_ready;
        r.playing = m_busy;
        return r;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [7:0] value);
        abpe_pkg::t_in req;
        req.kind = kind;
        req.value = value;
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_in <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_q.push_back(predict_result(req));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        drain();
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            abpe_pkg::REG_START: m_start = val;
            abpe_pkg::REG_END: m_end = val;
            abpe_pkg::REG_LIMIT: m_limit = val;
            abpe_pkg::REG_RATE: m_rate = val[19:0];
            abpe_pkg::REG_VOLUME: m_vol = val[7:0];
            default: m_pan = val[1:0];
        endcase
    endtask

    // checker
    initial begin
        pop = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result %p", $time, o_out);
                    errors++;
                end else if (expected_q[0] !== o_out) begin
                    $display("%0t mismatch expected %p actual %p", $time, expected_q[0], o_out);
                    errors++;
                    void'(expected_q.pop_front());
                end else void'(expected_q.pop_front());
            end
            pop <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    // fill [start, end) of the store through write mode
    task automatic load_store(input int first, input int count);
        write_reg(abpe_pkg::REG_START, 24'(first));
        write_reg(abpe_pkg::REG_END, 24'(first + count));
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_WR_M);
        for (int i = 0; i < count; i++)
            send_request(abpe_pkg::KIND_WRITE, 8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        write_reg(abpe_pkg::REG_VOLUME, 255);
        write_reg(abpe_pkg::REG_PAN, 3);
        load_store(0, 16);
        send_request(abpe_pkg::KIND_WRITE, 8'hFF);
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_RD_M);
        for (int i = 0; i < 19; i++) send_request(abpe_pkg::KIND_READ, 0);
        write_reg(abpe_pkg::REG_RATE, 20'hFFFFF);
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_M);
        for (int i = 0; i < 3; i++) send_request(abpe_pkg::KIND_TICK, 0);
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_M | 8'h10);
        for (int i = 0; i < 4; i++) send_request(abpe_pkg::KIND_TICK, 0);
        send_request(abpe_pkg::KIND_CTRL, 8'h01);
        write_reg(abpe_pkg::REG_START, 24'hFFFFFF);
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_M);
        send_request(abpe_pkg::KIND_TICK, 0);
    endtask

    task automatic test_limit_overrun();
        write_reg(abpe_pkg::REG_START, 24'(SB - 4));
        write_reg(abpe_pkg::REG_END, 24'hFFFFFF);
        write_reg(abpe_pkg::REG_LIMIT, 24'hFFFFFF);
        write_reg(abpe_pkg::REG_RATE, 20'h30000);
        load_store(SB - 4, 3);
        write_reg(abpe_pkg::REG_START, 0);
        write_reg(abpe_pkg::REG_END, 15);
        write_reg(abpe_pkg::REG_LIMIT, 4);
        write_reg(abpe_pkg::REG_VOLUME, 0);
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_M | 8'h10);
        for (int i = 0; i < 8; i++) send_request(abpe_pkg::KIND_TICK, 0);
        write_reg(abpe_pkg::REG_LIMIT, abpe_pkg::LIMIT_OFF);
        write_reg(abpe_pkg::REG_END, 24'hFFFFFF);
        write_reg(abpe_pkg::REG_START, 24'(SB - 1));
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_M);
        for (int i = 0; i < 3; i++) send_request(abpe_pkg::KIND_TICK, 0);
        write_reg(abpe_pkg::REG_START, 0);
    endtask

    task automatic test_random(input int items);
        int v, n;
        n = 0;
        while (n < items) begin
            v = $urandom_range(9);
            if (v < 2) begin
                write_reg(abpe_pkg::REG_START, 24'($urandom_range(200)));
                write_reg(abpe_pkg::REG_END, 24'($urandom_range(300)));
                write_reg(abpe_pkg::REG_LIMIT, ($urandom_range(3) == 0) ?
                          24'($urandom_range(300)) : abpe_pkg::LIMIT_OFF);
                write_reg(abpe_pkg::REG_RATE, ($urandom_range(3) == 0) ?
                          24'($urandom) : 24'($urandom_range(70000)));
                write_reg(abpe_pkg::REG_VOLUME, 24'($urandom_range(255)));
                write_reg(abpe_pkg::REG_PAN, 24'($urandom_range(3)));
            end
            send_request(abpe_pkg::KIND_CTRL, ($urandom_range(4) == 0) ?
                         8'($urandom_range(255)) :
                         {3'(5 - 2 * $urandom_range(1)), 1'($urandom), 4'h0});
            n++;
            for (int i = 0; i < 30; i++) begin
                v = $urandom_range(3);
                // keep store fetches inside written entries
                if (v == 3 && (m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_RD_M &&
                    m_dummy == 0 && (m_addr >> 1) < SB && !m_written[m_addr >> 1]) v = 0;
                if (v == 0 && (m_mode & abpe_pkg::MODE_SEL) == abpe_pkg::MODE_PLAY_M &&
                    tick_reads_unwritten()) v = 2;
                send_request(v[1:0], 8'($urandom_range(255)));
                n++;
            end
        end
    endtask

    task automatic test_backpressure();
        send_request(abpe_pkg::KIND_CTRL, abpe_pkg::MODE_PLAY_C);
        hold_recv = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_recv = 0;
            end
            for (int i = 0; i < 40; i++) send_request(abpe_pkg::KIND_TICK, 0);
        join
        drain();
        for (int i = 0; i < 10; i++) send_request(abpe_pkg::KIND_TICK, 0);
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        push = 0;
        i_in = '0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        m_start = 0; m_end = 0; m_limit = abpe_pkg::LIMIT_OFF; m_rate = 0; m_vol = 0;
        m_pan = 0;
        m_addr = 0; m_phase = 0; m_acc = 0; m_prev = 0; m_step = 127;
        m_held = 0; m_cpu = 0; m_mode = 0; m_busy = 0; m_ready = 1; m_dummy = 0;
        m_bad_read = 0;
        for (int i = 0; i < SB; i++) begin
            m_store[i] = 0;
            m_written[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_limit_overrun();
        test_random(700);
        send_idle = 48; recv_idle = 17;
        test_random(700);
        send_idle = 0; recv_idle = 0;
        test_random(600);
        test_backpressure();
        drain();
        if (errors == 0 && expected_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
